// ----- rtl/ktgf_pkg.sv -----
// ----------------------------------------------------------------------------
// ktgf_pkg
// Shared types and constants for the Kanai-Tajimi ground filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ktgf_pkg;

    // Digit-serial multiplier geometry: 32-bit multiplier operand, 4-bit digits
    localparam int DIGIT_W  = 4;
    localparam int N_DIGITS = 32 / DIGIT_W;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_ACCEL_GAIN      = 3'd0,
        REG_VELOC_GAIN      = 3'd1,
        REG_NOISE_DIFF_GAIN = 3'd2,
        REG_HALF_STEP       = 3'd3,
        REG_THREE_OVER_STEP = 3'd4,
        REG_NOISE_DRIVE     = 3'd5,
        REG_DAMPING_COEF    = 3'd6,
        REG_STIFFNESS_COEF  = 3'd7
    } t_reg_idx;

    // One product term per op, run in this order
    typedef enum logic [2:0] {
        OP_ACC_GAIN    = 3'd0,  // + accel_gain * acc
        OP_VEL_GAIN    = 3'd1,  // + veloc_gain * vel
        OP_NOISE_DIFF  = 3'd2,  // + noise_diff_gain * (n - p), closes Dd
        OP_HALF_STEP   = 3'd3,  // - half_step * acc
        OP_THREE_STEP  = 3'd4,  // + three_over_step * Dd, closes velocity
        OP_NOISE_DRIVE = 3'd5,  // + noise_drive * n
        OP_DAMPING     = 3'd6,  // - damping_coef * vel, also the output term
        OP_STIFFNESS   = 3'd7   // - stiffness_coef * disp, closes acceleration
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MUL,
        ST_ACCUM,
        ST_SAT,
        ST_UPDATE
    } t_state;

    typedef struct packed {
        logic [31:0] accel_gain;
        logic [31:0] veloc_gain;
        logic [31:0] noise_diff_gain;
        logic [30:0] half_step;
        logic [30:0] three_over_step;
        logic [31:0] noise_drive;
        logic [31:0] damping_coef;
        logic [31:0] stiffness_coef;
    } t_coefs;

    typedef struct packed {
        logic busy;       // item in flight, input side stalled
        logic accept;     // input item taken this cycle
        logic mul_start;  // launch multiply for current op
        logic accum;      // fold rounded product into running sum
        logic sat;        // clamp running sum
        logic update;     // commit closed sum to state
        t_op  op;
    } t_ctrl;

endpackage : ktgf_pkg

`default_nettype wire

// ----- rtl/ktgf_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ktgf_cfg_regs
// APB register file holding the eight filter coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module ktgf_cfg_regs
    import ktgf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output t_coefs           o_coefs
);

    t_coefs   r_coefs;
    t_reg_idx w_idx;
    logic     w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ACCEL_GAIN:      r_coefs.accel_gain      <= pwdata;
                REG_VELOC_GAIN:      r_coefs.veloc_gain      <= pwdata;
                REG_NOISE_DIFF_GAIN: r_coefs.noise_diff_gain <= pwdata;
                REG_HALF_STEP:       r_coefs.half_step       <= pwdata[30:0];
                REG_THREE_OVER_STEP: r_coefs.three_over_step <= pwdata[30:0];
                REG_NOISE_DRIVE:     r_coefs.noise_drive     <= pwdata;
                REG_DAMPING_COEF:    r_coefs.damping_coef    <= pwdata;
                REG_STIFFNESS_COEF:  r_coefs.stiffness_coef  <= pwdata;
                default:             r_coefs                 <= r_coefs;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_ACCEL_GAIN:      prdata = r_coefs.accel_gain;
            REG_VELOC_GAIN:      prdata = r_coefs.veloc_gain;
            REG_NOISE_DIFF_GAIN: prdata = r_coefs.noise_diff_gain;
            REG_HALF_STEP:       prdata = {1'b0, r_coefs.half_step};
            REG_THREE_OVER_STEP: prdata = {1'b0, r_coefs.three_over_step};
            REG_NOISE_DRIVE:     prdata = r_coefs.noise_drive;
            REG_DAMPING_COEF:    prdata = r_coefs.damping_coef;
            REG_STIFFNESS_COEF:  prdata = r_coefs.stiffness_coef;
            default:             prdata = '0;
        endcase
    end

    assign o_coefs = r_coefs;

endmodule : ktgf_cfg_regs

`default_nettype wire

// ----- rtl/ktgf_digit_mult.sv -----
// ----------------------------------------------------------------------------
// ktgf_digit_mult
// Digit-serial signed 32x32 multiplier, one 4-bit digit per cycle, with the
// half-LSB rounding constant preloaded into the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module ktgf_digit_mult
    import ktgf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic                    o_done,
    output logic signed [63:0]      o_product
);

    localparam int ACC_W = 32 + DIGIT_W + 1;
    localparam int CNT_W = $clog2(N_DIGITS);
    // product + 2^(FRAC_BITS-1): constant enters at weight one
    localparam logic signed [ACC_W-1:0] RND_INIT = ACC_W'(64'd1 << (FRAC_BITS - 1));

    logic                    r_busy;
    logic [CNT_W-1:0]        r_cnt;
    logic signed [31:0]      r_a;
    logic [31:0]             r_b;
    logic signed [ACC_W-1:0] r_acc_hi;
    logic [31:0]             r_lo;

    logic                    w_last;
    logic signed [DIGIT_W:0] w_digit;
    logic signed [ACC_W-1:0] w_pp;
    logic signed [ACC_W-1:0] w_sum;

    assign w_last  = (r_cnt == CNT_W'(N_DIGITS - 1));
    // top digit carries the operand sign, the rest are unsigned
    assign w_digit = {w_last & r_b[DIGIT_W-1], r_b[DIGIT_W-1:0]};
    assign w_pp    = ACC_W'(r_a) * ACC_W'(w_digit);
    assign w_sum   = r_acc_hi + w_pp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_busy <= !w_last;
            r_cnt  <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a      <= i_a;
            r_b      <= i_b;
            r_acc_hi <= RND_INIT;
            r_lo     <= '0;
        end else if (r_busy) begin
            r_b      <= r_b >> DIGIT_W;
            r_acc_hi <= w_sum >>> DIGIT_W;
            r_lo     <= {w_sum[DIGIT_W-1:0], r_lo[31:DIGIT_W]};
        end
    end

    assign o_done    = r_busy && w_last;
    assign o_product = {r_acc_hi[31:0], r_lo};

endmodule : ktgf_digit_mult

`default_nettype wire

// ----- rtl/ktgf_seq.sv -----
// ----------------------------------------------------------------------------
// ktgf_seq
// Sequencer stepping the eight product terms of one filter update.
// ----------------------------------------------------------------------------
`default_nettype none

module ktgf_seq
    import ktgf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_mul_done,
    input  wire logic i_out_free,
    output t_ctrl     o_ctrl
);

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   w_closes;

    // ops that close a sum and need clamp + commit
    assign w_closes = (r_op == OP_NOISE_DIFF) || (r_op == OP_THREE_STEP)
                   || (r_op == OP_STIFFNESS);

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_START;
                    n_op    = OP_ACC_GAIN;
                end
            end
            ST_START: n_state = ST_MUL;
            ST_MUL: begin
                if (i_mul_done) n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                if (w_closes) begin
                    n_state = ST_SAT;
                end else begin
                    n_state = ST_START;
                    n_op    = t_op'(3'(r_op + 1'b1));
                end
            end
            ST_SAT: n_state = ST_UPDATE;
            ST_UPDATE: begin
                if (r_op != OP_STIFFNESS) begin
                    n_state = ST_START;
                    n_op    = t_op'(3'(r_op + 1'b1));
                end else if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl.busy      = (r_state != ST_IDLE);
        o_ctrl.accept    = (r_state == ST_IDLE) && i_in_valid;
        o_ctrl.mul_start = (r_state == ST_START);
        o_ctrl.accum     = (r_state == ST_ACCUM);
        o_ctrl.sat       = (r_state == ST_SAT);
        o_ctrl.update    = (r_state == ST_UPDATE)
                        && ((r_op != OP_STIFFNESS) || i_out_free);
        o_ctrl.op        = r_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_ACC_GAIN;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

endmodule : ktgf_seq

`default_nettype wire

// ----- rtl/kanai_tajimi_ground_filter.sv -----
// ----------------------------------------------------------------------------
// kanai_tajimi_ground_filter
// Kanai-Tajimi ground acceleration filter, linear-acceleration stepping,
// signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one noise item: i_noise_sample
//   (Q3.16) and i_restart, which clears displacement, velocity, acceleration
//   and the previous noise before that item is processed.
//   Output channel (o_valid / i_stall) returns one o_ground_accel item per
//   input item: damping_coef times the new velocity, saturated to 32 bits.
//   Coefficients are written over the APB port (byte address 4*index) while
//   no item is in flight; pready is always high.
// Timing:
//   Eight product terms run through one digit-serial multiplier, 4 bits of
//   the multiplier operand per cycle. Each term is a launch, 8 digit steps
//   and an accumulate; the three sums that close (Dd, velocity,
//   acceleration) add a clamp and a commit each. The result is registered
//   at the final commit of the item, and a new item is taken once the
//   sequencer is back in idle.
// Reset clears coefficients, filter state and the output valid flag.
// A stalled output item holds; the next item is still taken, and its final
// commit waits until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module kanai_tajimi_ground_filter
    import ktgf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // input item channel
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic signed [19:0] i_noise_sample,
    input  wire logic               i_restart,
    // result item channel
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_ground_accel,
    // configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [4:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    // rounded product and running-sum widths follow from the Q format
    localparam int PROD_W = 64 - FRAC_BITS;
    localparam int SUM_W  = PROD_W + 2;

    localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(32'sh7FFF_FFFF);
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(32'sh8000_0000);
    localparam logic signed [PROD_W-1:0] PROD_MAX = PROD_W'(32'sh7FFF_FFFF);
    localparam logic signed [PROD_W-1:0] PROD_MIN = PROD_W'(32'sh8000_0000);

    t_coefs w_coefs;
    t_ctrl  w_ctrl;

    // filter state
    logic signed [31:0] r_disp;
    logic signed [31:0] r_vel;
    logic signed [31:0] r_acc;
    logic signed [19:0] r_prev;

    // per-item working registers
    logic signed [19:0]      r_n;
    logic signed [31:0]      r_dd;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [31:0]      r_sat;
    logic signed [31:0]      r_y;

    // result register
    logic               r_out_valid;
    logic signed [31:0] r_out_data;

    logic                     w_out_free;
    logic                     w_mul_done;
    logic signed [31:0]       w_mul_a;
    logic signed [31:0]       w_mul_b;
    logic signed [63:0]       w_prod;
    logic signed [PROD_W-1:0] w_rp;
    logic signed [SUM_W-1:0]  w_rp_ext;
    logic signed [20:0]       w_ndiff;
    logic                     w_sub;
    logic signed [32:0]       w_disp_sum;
    logic signed [31:0]       w_disp_sat;
    logic signed [SUM_W-1:0]  w_neg2vel;
    logic                     w_upd_last;

    function automatic logic signed [31:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [31:0] r;
        if (v > SUM_MAX)      r = 32'sh7FFF_FFFF;
        else if (v < SUM_MIN) r = 32'sh8000_0000;
        else                  r = v[31:0];
        return r;
    endfunction

    function automatic logic signed [31:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > PROD_MAX)      r = 32'sh7FFF_FFFF;
        else if (v < PROD_MIN) r = 32'sh8000_0000;
        else                   r = v[31:0];
        return r;
    endfunction

    ktgf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coefs (w_coefs)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    ktgf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_mul_done (w_mul_done),
        .i_out_free (w_out_free),
        .o_ctrl     (w_ctrl)
    );

    // noise difference n - p, one bit wider than the samples
    assign w_ndiff = {r_n[19], r_n} - {r_prev[19], r_prev};

    // operand select: coefficient on a, state term on b (digit-serial side)
    always_comb begin
        unique case (w_ctrl.op)
            OP_ACC_GAIN: begin
                w_mul_a = w_coefs.accel_gain;
                w_mul_b = r_acc;
                w_sub   = 1'b0;
            end
            OP_VEL_GAIN: begin
                w_mul_a = w_coefs.veloc_gain;
                w_mul_b = r_vel;
                w_sub   = 1'b0;
            end
            OP_NOISE_DIFF: begin
                w_mul_a = w_coefs.noise_diff_gain;
                w_mul_b = 32'(w_ndiff);
                w_sub   = 1'b0;
            end
            OP_HALF_STEP: begin
                w_mul_a = {1'b0, w_coefs.half_step};
                w_mul_b = r_acc;
                w_sub   = 1'b1;
            end
            OP_THREE_STEP: begin
                w_mul_a = {1'b0, w_coefs.three_over_step};
                w_mul_b = r_dd;
                w_sub   = 1'b0;
            end
            OP_NOISE_DRIVE: begin
                w_mul_a = w_coefs.noise_drive;
                w_mul_b = 32'(r_n);
                w_sub   = 1'b0;
            end
            OP_DAMPING: begin
                w_mul_a = w_coefs.damping_coef;
                w_mul_b = r_vel;
                w_sub   = 1'b1;
            end
            OP_STIFFNESS: begin
                w_mul_a = w_coefs.stiffness_coef;
                w_mul_b = r_disp;
                w_sub   = 1'b1;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
                w_sub   = 1'b0;
            end
        endcase
    end

    ktgf_digit_mult #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_ctrl.mul_start),
        .i_a       (w_mul_a),
        .i_b       (w_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    // rounding constant is already in the product: rescale is a bit select
    assign w_rp      = w_prod[63:FRAC_BITS];
    assign w_rp_ext  = SUM_W'(w_rp);

    // displacement += Dd, clamped
    assign w_disp_sum = {r_disp[31], r_disp} + {r_sat[31], r_sat};
    assign w_disp_sat = (w_disp_sum[32] != w_disp_sum[31])
                      ? (w_disp_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                      : w_disp_sum[31:0];

    // velocity sum starts from -2 * old velocity
    assign w_neg2vel  = -(SUM_W'(r_vel) <<< 1);

    assign w_upd_last = w_ctrl.update && (w_ctrl.op == OP_STIFFNESS);

    // filter state: cleared at reset and on a restart item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disp <= '0;
            r_vel  <= '0;
            r_acc  <= '0;
            r_prev <= '0;
        end else if (w_ctrl.accept && i_restart) begin
            r_disp <= '0;
            r_vel  <= '0;
            r_acc  <= '0;
            r_prev <= '0;
        end else if (w_ctrl.update) begin
            unique case (w_ctrl.op)
                OP_NOISE_DIFF: r_disp <= w_disp_sat;
                OP_THREE_STEP: r_vel  <= r_sat;
                OP_STIFFNESS: begin
                    r_acc  <= r_sat;
                    r_prev <= r_n;
                end
                default: r_disp <= r_disp;
            endcase
        end
    end

    // working registers, payload only
    always_ff @(posedge i_clk) begin
        if (w_ctrl.accept) begin
            r_n   <= i_noise_sample;
            r_sum <= '0;
        end
        if (w_ctrl.accum) begin
            r_sum <= w_sub ? (r_sum - w_rp_ext) : (r_sum + w_rp_ext);
            // the damping term doubles as the output value
            if (w_ctrl.op == OP_DAMPING) r_y <= sat_prod(w_rp);
        end
        if (w_ctrl.sat) begin
            r_sat <= sat_sum(r_sum);
        end
        if (w_ctrl.update) begin
            unique case (w_ctrl.op)
                OP_NOISE_DIFF: begin
                    r_dd  <= r_sat;
                    r_sum <= w_neg2vel;
                end
                OP_THREE_STEP: r_sum <= '0;
                default:       r_sum <= r_sum;
            endcase
        end
    end

    // result register: holds while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_upd_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_upd_last) r_out_data <= r_y;
    end

    assign o_stall        = w_ctrl.busy;
    assign o_valid        = r_out_valid;
    assign o_ground_accel = r_out_data;

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_out_valid && i_stall && w_upd_last))
        else $error("result overwritten while stalled");

    // a new result appears only from the final commit of an item
    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(w_upd_last))
        else $error("o_valid rose without a commit");

    // once an item is taken the input side stalls
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.accept |=> o_stall)
        else $error("input not stalled after accept");

endmodule : kanai_tajimi_ground_filter

`default_nettype wire
